[rtl/core/ptsb_pkg.sv]
`timescale 1ns / 1ps

package ptsb_pkg;

  localparam int OP_W     = 3;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 16;
  localparam int STATUS_W = 3;
  localparam int GRANT_W  = 3;
  localparam int MASK_W   = 8;

  localparam int MAX_SLOTS       = 8;
  localparam int DEF_SLOT_COUNT  = 8;
  localparam logic [PERIOD_W-1:0] RESET_MIN_PERIOD = 16'd5;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register word index, taken from paddr above the byte offset
  typedef enum logic [0:0] {
    REG_MIN_PERIOD = 1'b0
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_ALLOCATE = 3'd1,
    OP_ENABLE   = 3'd2,
    OP_DISABLE  = 3'd3,
    OP_RELEASE  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NO_FREE  = 3'd2,
    ST_UNINIT   = 3'd3,
    ST_ALL_FREE = 3'd4
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [GRANT_W-1:0]  granted_slot;
    logic [MASK_W-1:0]   fired_mask;
  } result_t;

endpackage

[rtl/core/periodic_timer_slot_bank_unit.sv]
`timescale 1ns / 1ps

// Bank of up to eight periodic timer slots driven by one command beat at a
// time: tick, allocate, enable, disable and release. Every input beat gives
// exactly one result beat with a status, the slot granted by allocate and,
// on a tick, the mask of slots that expired and reloaded. The block takes
// one beat per cycle while the result side is not stalled: a beat lands in
// the input register, the slot update logic works on it in a single pass
// and the result lands in the output register, which raises out_valid.
// Back-pressure on the result side stalls the pass and then the input.
// min_period (word 0 of the register port, reset 5) sets the smallest
// period that allocate accepts; write it only while the block is idle.

module periodic_timer_slot_bank_unit #(
  parameter int SLOT_COUNT = ptsb_pkg::DEF_SLOT_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptsb_pkg::OP_W-1:0]     in_operation,
  input  logic [ptsb_pkg::SLOT_W-1:0]   in_slot,
  input  logic [ptsb_pkg::PERIOD_W-1:0] in_period,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptsb_pkg::STATUS_W-1:0] out_status,
  output logic [ptsb_pkg::GRANT_W-1:0]  out_granted_slot,
  output logic [ptsb_pkg::MASK_W-1:0]   out_fired_mask,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptsb_pkg::PADDR_W-1:0]  paddr,
  input  logic [ptsb_pkg::PDATA_W-1:0]  pwdata,
  output logic [ptsb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ptsb_pkg::*;

  logic [PERIOD_W-1:0] min_period;

  // input register
  logic    in_valid_r;
  logic    in_valid_nxt;
  item_t   item_r;

  // output register
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t res_r;
  result_t res_comb;

  // the held beat is processed when the output register is free or draining
  logic    fire;
  logic    in_take;

  ptsb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .min_period (min_period)
  );

  ptsb_bank #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (item_r),
    .min_period (min_period),
    .result     (res_comb)
  );

  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.operation <= in_operation;
      item_r.slot      <= in_slot;
      item_r.period    <= in_period;
    end
    if (fire) begin
      res_r <= res_comb;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_granted_slot = res_r.granted_slot;
  assign out_fired_mask   = res_r.fired_mask;

endmodule

[rtl/core/ptsb_regs.sv]
`timescale 1ns / 1ps

module ptsb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptsb_pkg::PADDR_W-1:0]  paddr,
  input  logic [ptsb_pkg::PDATA_W-1:0]  pwdata,
  output logic [ptsb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [ptsb_pkg::PERIOD_W-1:0] min_period
);
  import ptsb_pkg::*;

  logic [PERIOD_W-1:0] min_period_r;
  logic [PERIOD_W-1:0] min_period_nxt;
  logic                sel_min;

  // low two address bits are the byte offset
  assign sel_min = (paddr[PADDR_W-1:2] == REG_MIN_PERIOD);
  assign pready  = 1'b1;

  always_comb begin
    min_period_nxt = min_period_r;
    if (psel && penable && pwrite && pready && sel_min) begin
      min_period_nxt = pwdata[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= RESET_MIN_PERIOD;
    end else begin
      min_period_r <= min_period_nxt;
    end
  end

  assign prdata     = sel_min ? PDATA_W'(min_period_r) : '0;
  assign min_period = min_period_r;

endmodule

[rtl/core/ptsb_bank.sv]
`timescale 1ns / 1ps

module ptsb_bank #(
  parameter int SLOT_COUNT = ptsb_pkg::DEF_SLOT_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  ptsb_pkg::item_t               item,
  input  logic [ptsb_pkg::PERIOD_W-1:0] min_period,
  output ptsb_pkg::result_t             result
);
  import ptsb_pkg::*;

  logic [PERIOD_W-1:0]   cnt_r   [SLOT_COUNT];
  logic [PERIOD_W-1:0]   cnt_nxt [SLOT_COUNT];
  logic [PERIOD_W-1:0]   per_r   [SLOT_COUNT];
  logic [PERIOD_W-1:0]   per_nxt [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] en_r;
  logic [SLOT_COUNT-1:0] en_nxt;
  logic [SLOT_COUNT-1:0] alloc_r;
  logic [SLOT_COUNT-1:0] alloc_nxt;

  always_comb begin
    logic [SLOT_COUNT-1:0] hit;
    logic [SLOT_COUNT-1:0] per_zero;
    logic [SLOT_COUNT-1:0] fired;
    logic [SLOT_COUNT-1:0] grant_oh;
    logic [GRANT_W-1:0]    grant_idx;
    logic                  slot_ok;
    logic [PERIOD_W-1:0]   dec;

    for (int i = 0; i < SLOT_COUNT; i++) begin
      cnt_nxt[i] = cnt_r[i];
      per_nxt[i] = per_r[i];
    end
    en_nxt    = en_r;
    alloc_nxt = alloc_r;
    fired     = '0;
    grant_oh  = '0;
    grant_idx = '0;
    dec       = '0;

    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i]      = (item.slot == SLOT_W'(i));
      per_zero[i] = (per_r[i] == '0);
    end
    slot_ok = (item.slot < SLOT_W'(SLOT_COUNT));

    // lowest free slot
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!alloc_r[i]) begin
        grant_oh  = SLOT_COUNT'(1) << i;
        grant_idx = GRANT_W'(i);
      end
    end

    result.status       = ST_OK;
    result.granted_slot = '0;
    result.fired_mask   = '0;

    unique case (item.operation)
      OP_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          dec = (cnt_r[i] != '0) ? cnt_r[i] - 1'b1 : '0;
          cnt_nxt[i] = dec;
          if (en_r[i] && alloc_r[i] && dec == '0) begin
            cnt_nxt[i] = per_r[i];
            fired[i]   = 1'b1;
          end
        end
        result.fired_mask = MASK_W'(fired);
      end
      OP_ALLOCATE: begin
        if (item.period < min_period) begin
          result.status = ST_INVALID;
        end else if (&alloc_r) begin
          result.status = ST_NO_FREE;
        end else begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (grant_oh[i]) begin
              per_nxt[i] = item.period;
              cnt_nxt[i] = item.period;
            end
          end
          alloc_nxt           = alloc_r | grant_oh;
          en_nxt              = en_r & ~grant_oh;
          result.granted_slot = grant_idx;
        end
      end
      OP_ENABLE, OP_DISABLE: begin
        if (!slot_ok) begin
          result.status = ST_INVALID;
        end else if (|(hit & per_zero)) begin
          result.status = ST_UNINIT;
        end else if (item.operation == OP_ENABLE) begin
          en_nxt = en_r | hit;
        end else begin
          en_nxt = en_r & ~hit;
        end
      end
      OP_RELEASE: begin
        if (!slot_ok) begin
          result.status = ST_INVALID;
        end else if (alloc_r == '0) begin
          result.status = ST_ALL_FREE;
        end else begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (hit[i]) begin
              per_nxt[i] = '0;
            end
          end
          en_nxt    = en_r & ~hit;
          alloc_nxt = alloc_r & ~hit;
        end
      end
      default: begin
        result.status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cnt_r[i] <= '0;
        per_r[i] <= '0;
      end
      en_r    <= '0;
      alloc_r <= '0;
    end else if (fire) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cnt_r[i] <= cnt_nxt[i];
        per_r[i] <= per_nxt[i];
      end
      en_r    <= en_nxt;
      alloc_r <= alloc_nxt;
    end
  end

endmodule
